@@ hw/rtl/vbpc_pkg.sv @@
// shared types, constants and helpers for the vehicle box / point collision unit
package vbpc_pkg;

	localparam int COORD_W = 32;
	localparam int CFG_W   = 24;
	localparam int TRIG_W  = 16;
	localparam int CIDX_W  = 2;

	typedef logic signed [COORD_W-1:0] coord_t;

	localparam coord_t COORD_MAX = 32'sh7FFF_FFFF;
	localparam coord_t COORD_MIN = 32'sh8000_0000;

	typedef enum logic {
		FUNC_POSE  = 1'b0,
		FUNC_POINT = 1'b1
	} func_t;

	typedef enum logic [CIDX_W-1:0] {
		CFG_REAR_OVERHANG  = 2'd0,
		CFG_WHEELBASE      = 2'd1,
		CFG_FRONT_OVERHANG = 2'd2,
		CFG_VEHICLE_WIDTH  = 2'd3
	} cfg_idx_t;

	// item as it enters the box stage: point coords plus partial corner bounds
	typedef struct packed {
		func_t  func;
		logic   last;
		coord_t x;
		coord_t y;
		coord_t min_x_a;
		coord_t max_x_a;
		coord_t min_y_a;
		coord_t max_y_a;
		coord_t min_x_b;
		coord_t max_x_b;
		coord_t min_y_b;
		coord_t max_y_b;
	} s5_item_t;

	function automatic coord_t smin(coord_t a, coord_t b);
		return (a < b) ? a : b;
	endfunction

	function automatic coord_t smax(coord_t a, coord_t b);
		return (a > b) ? a : b;
	endfunction

endpackage

@@ hw/rtl/vbpc_box_unit.sv @@
// bounding box state, sticky hit flag and result register
module vbpc_box_unit
	import vbpc_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     v_s5,
	input  s5_item_t item_s5,
	output logic     go,
	output logic     out_valid,
	input  logic     out_ready,
	output logic     collision
);

	coord_t box_min_x_q, box_max_x_q, box_min_y_q, box_max_y_q;
	logic   hit_q;
	logic   out_valid_q, collision_q;

	coord_t new_min_x, new_max_x, new_min_y, new_max_y;
	logic   out_free, retire, inbox, hit_next, res_bit;

	assign out_free = !out_valid_q || out_ready;
	// items that do not end a list never need the result slot
	assign go       = !v_s5 || !item_s5.last || out_free;
	assign retire   = v_s5 && go;

	always_comb begin
		new_min_x = smin(item_s5.min_x_a, item_s5.min_x_b);
		new_max_x = smax(item_s5.max_x_a, item_s5.max_x_b);
		new_min_y = smin(item_s5.min_y_a, item_s5.min_y_b);
		new_max_y = smax(item_s5.max_y_a, item_s5.max_y_b);
		inbox = (item_s5.x >= box_min_x_q) && (item_s5.x <= box_max_x_q) &&
			(item_s5.y >= box_min_y_q) && (item_s5.y <= box_max_y_q);
		hit_next = hit_q || inbox;
		res_bit  = (item_s5.func == FUNC_POINT) ? hit_next : 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_min_x_q <= COORD_MAX;
			box_max_x_q <= COORD_MIN;
			box_min_y_q <= COORD_MAX;
			box_max_y_q <= COORD_MIN;
			hit_q       <= 1'b0;
		end else if (retire) begin
			if (item_s5.func == FUNC_POSE) begin
				box_min_x_q <= new_min_x;
				box_max_x_q <= new_max_x;
				box_min_y_q <= new_min_y;
				box_max_y_q <= new_max_y;
				hit_q       <= 1'b0;
			end else begin
				hit_q <= hit_next;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (retire && item_s5.last) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (retire && item_s5.last) begin
			collision_q <= res_bit;
		end
	end

	assign out_valid = out_valid_q;
	assign collision = collision_q;

`ifndef SYNTHESIS
	a_pose_clears_hit: assert property (@(posedge clk) disable iff (!arst_n)
		retire && item_s5.func == FUNC_POSE |=> !hit_q)
		else $error("hit flag not cleared by pose");

	a_pose_last_zero: assert property (@(posedge clk) disable iff (!arst_n)
		retire && item_s5.func == FUNC_POSE && item_s5.last |=> out_valid_q && !collision_q)
		else $error("pose ending a list must report no collision");

	a_hit_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		retire && item_s5.func == FUNC_POINT && hit_q |=> hit_q)
		else $error("hit flag dropped by a point");

	a_result_matches_flag: assert property (@(posedge clk) disable iff (!arst_n)
		retire && item_s5.func == FUNC_POINT && item_s5.last |=> collision_q == hit_q)
		else $error("result differs from hit flag");
`endif

endmodule

@@ hw/rtl/vehicle_box_point_collision_unit.sv @@
// top level of the vehicle box / obstacle point collision unit
// A pose transaction (func = 0) carries the rear-axle position and the yaw cosine
// and sine; the unit rotates the four body corners into world coordinates, keeps
// their axis-aligned bounding box and clears the hit flag. Each point transaction
// (func = 1) is tested against that box with inclusive bounds and a hit sticks.
// The transaction marked last yields one result with the flag (a pose marked last
// gives 0). Throughput is one transaction per clock unless the input is stalled;
// a result reaches out_valid through the five pipeline stages (input register,
// multipliers, offset add, saturating sum, bound pairing) ahead of the box stage
// and its result register. Input is held off only while a finished result waits,
// a last item is in the box stage and the pipeline has filled. Configuration
// writes are always taken and must only happen while the unit is empty.
module vehicle_box_point_collision_unit
	import vbpc_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	// item input channel
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic                     func,
	input  logic signed [COORD_W-1:0] coord_x,
	input  logic signed [COORD_W-1:0] coord_y,
	input  logic signed [TRIG_W-1:0]  cos_yaw,
	input  logic signed [TRIG_W-1:0]  sin_yaw,
	input  logic                     last,
	// result channel
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic                     collision,
	// configuration write channel
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [CIDX_W-1:0]        cfg_index,
	input  logic [CFG_W-1:0]         cfg_data
);

	localparam int XS_W   = CFG_W + 2;          // corner x, signed
	localparam int WS_W   = CFG_W + 1;          // width, signed
	localparam int PX_W   = XS_W + TRIG_W;      // corner x times trig
	localparam int PW_W   = WS_W + TRIG_W;      // width times trig
	localparam int SUM_W  = PX_W + 2;           // Q.31 corner offset
	localparam int FRAC_D = 15;                 // Q.31 -> Q.16
	localparam int OFF_W  = SUM_W - FRAC_D;

	// configuration registers
	logic [CFG_W-1:0] rear_q, wb_q, front_q, width_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rear_q  <= 24'd65536;
			wb_q    <= 24'd180224;
			front_q <= 24'd65536;
			width_q <= 24'd122880;
		end else if (cfg_valid) begin
			case (cfg_idx_t'(cfg_index))
				CFG_REAR_OVERHANG:  rear_q  <= cfg_data;
				CFG_WHEELBASE:      wb_q    <= cfg_data;
				CFG_FRONT_OVERHANG: front_q <= cfg_data;
				CFG_VEHICLE_WIDTH:  width_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg_ready = 1'b1;

	// corner x offsets, width: user keeps fixed while the unit is busy, not enforced
	logic signed [XS_W-1:0] xs_rear, xs_front;
	logic signed [WS_W-1:0] w_sgn;

	assign xs_rear  = -$signed({2'b00, rear_q});
	assign xs_front = $signed({2'b00, wb_q} + {2'b00, front_q});
	assign w_sgn    = $signed({1'b0, width_q});

	// pipeline valids and stall chain, each stage moves when its successor has room
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic rdy1, rdy2, rdy3, rdy4, rdy5;

	assign rdy4     = !v_s4 || rdy5;
	assign rdy3     = !v_s3 || rdy4;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign in_ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
			if (rdy5) v_s5 <= v_s4;
		end
	end

	// stage 1: input register
	func_t                    func_s1;
	logic                     last_s1;
	coord_t                   x_s1, y_s1;
	logic signed [TRIG_W-1:0] cos_s1, sin_s1;

	always_ff @(posedge clk) begin
		if (rdy1) begin
			func_s1 <= func_t'(func);
			last_s1 <= last;
			x_s1    <= coord_x;
			y_s1    <= coord_y;
			cos_s1  <= cos_yaw;
			sin_s1  <= sin_yaw;
		end
	end

	// stage 2: the six products
	func_t                  func_s2;
	logic                   last_s2;
	coord_t                 x_s2, y_s2;
	logic signed [PX_W-1:0] rc_s2, rs_s2, fc_s2, fs_s2;
	logic signed [PW_W-1:0] wc_s2, ws_s2;

	always_ff @(posedge clk) begin
		if (rdy2) begin
			func_s2 <= func_s1;
			last_s2 <= last_s1;
			x_s2    <= x_s1;
			y_s2    <= y_s1;
			rc_s2   <= xs_rear * cos_s1;
			rs_s2   <= xs_rear * sin_s1;
			fc_s2   <= xs_front * cos_s1;
			fs_s2   <= xs_front * sin_s1;
			wc_s2   <= w_sgn * cos_s1;
			ws_s2   <= w_sgn * sin_s1;
		end
	end

	// stage 3: corner offsets in Q.31, floored to Q.16 by an arithmetic shift
	// corner order: rear/+w, rear/-w, front/+w, front/-w
	logic signed [SUM_W-1:0] rc2, rs2, fc2, fs2, wc_e, ws_e;
	logic signed [SUM_W-1:0] dx_c [4];
	logic signed [SUM_W-1:0] dy_c [4];
	func_t                   func_s3;
	logic                    last_s3;
	coord_t                  x_s3, y_s3;
	logic signed [OFF_W-1:0] offx_s3 [4];
	logic signed [OFF_W-1:0] offy_s3 [4];

	always_comb begin
		rc2  = {rc_s2[PX_W-1], rc_s2, 1'b0};
		rs2  = {rs_s2[PX_W-1], rs_s2, 1'b0};
		fc2  = {fc_s2[PX_W-1], fc_s2, 1'b0};
		fs2  = {fs_s2[PX_W-1], fs_s2, 1'b0};
		wc_e = {{(SUM_W-PW_W){wc_s2[PW_W-1]}}, wc_s2};
		ws_e = {{(SUM_W-PW_W){ws_s2[PW_W-1]}}, ws_s2};
		dx_c[0] = rc2 - ws_e;
		dy_c[0] = rs2 + wc_e;
		dx_c[1] = rc2 + ws_e;
		dy_c[1] = rs2 - wc_e;
		dx_c[2] = fc2 - ws_e;
		dy_c[2] = fs2 + wc_e;
		dx_c[3] = fc2 + ws_e;
		dy_c[3] = fs2 - wc_e;
	end

	always_ff @(posedge clk) begin
		if (rdy3) begin
			func_s3 <= func_s2;
			last_s3 <= last_s2;
			x_s3    <= x_s2;
			y_s3    <= y_s2;
			for (int k = 0; k < 4; k++) begin
				offx_s3[k] <= dx_c[k][SUM_W-1:FRAC_D];
				offy_s3[k] <= dy_c[k][SUM_W-1:FRAC_D];
			end
		end
	end

	// stage 4: world corners with saturation
	function automatic coord_t sat_add(coord_t base, logic signed [OFF_W-1:0] off);
		logic [COORD_W:0] sum;
		sum = {base[COORD_W-1], base} + {{(COORD_W+1-OFF_W){off[OFF_W-1]}}, off};
		if (sum[COORD_W] != sum[COORD_W-1]) begin
			return sum[COORD_W] ? COORD_MIN : COORD_MAX;
		end
		return coord_t'(sum[COORD_W-1:0]);
	endfunction

	func_t  func_s4;
	logic   last_s4;
	coord_t x_s4, y_s4;
	coord_t cx_s4 [4];
	coord_t cy_s4 [4];

	always_ff @(posedge clk) begin
		if (rdy4) begin
			func_s4 <= func_s3;
			last_s4 <= last_s3;
			x_s4    <= x_s3;
			y_s4    <= y_s3;
			for (int k = 0; k < 4; k++) begin
				cx_s4[k] <= sat_add(x_s3, offx_s3[k]);
				cy_s4[k] <= sat_add(y_s3, offy_s3[k]);
			end
		end
	end

	// stage 5: bounds of the rear corner pair and of the front corner pair
	s5_item_t item_s5;

	always_ff @(posedge clk) begin
		if (rdy5) begin
			item_s5.func    <= func_s4;
			item_s5.last    <= last_s4;
			item_s5.x       <= x_s4;
			item_s5.y       <= y_s4;
			item_s5.min_x_a <= smin(cx_s4[0], cx_s4[1]);
			item_s5.max_x_a <= smax(cx_s4[0], cx_s4[1]);
			item_s5.min_y_a <= smin(cy_s4[0], cy_s4[1]);
			item_s5.max_y_a <= smax(cy_s4[0], cy_s4[1]);
			item_s5.min_x_b <= smin(cx_s4[2], cx_s4[3]);
			item_s5.max_x_b <= smax(cx_s4[2], cx_s4[3]);
			item_s5.min_y_b <= smin(cy_s4[2], cy_s4[3]);
			item_s5.max_y_b <= smax(cy_s4[2], cy_s4[3]);
		end
	end

	// box stage: final bounds, point test, hit flag and result register
	vbpc_box_unit u_box (
		.clk       (clk),
		.arst_n    (arst_n),
		.v_s5      (v_s5),
		.item_s5   (item_s5),
		.go        (rdy5),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.collision (collision)
	);

endmodule
